@@ sv/bufr_numeric_field_unpack_assert.svh @@
// Assertion macros used by the port-level checker of the numeric field unpacker.
`ifndef BUFR_NUMERIC_FIELD_UNPACK_ASSERT_SVH
`define BUFR_NUMERIC_FIELD_UNPACK_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define BNFU_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define BNFU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/bnfu_pkg.sv @@
// Types, codes and helpers of the numeric field unpacker.
package bnfu_pkg;

   localparam int DEF_MAX_SUBSETS = 1024;
   localparam int DEF_MAX_WIDTH   = 32;
   localparam int BUF_BITS        = 16;
   localparam int DIFF_WIDTH_BITS = 6;
   localparam int BITS_PER_STEP   = 8;
   localparam int HELD_W          = 5;
   localparam int STEP_W          = 4;

   localparam logic [1:0] OP_DATA = 2'd0;
   localparam logic [1:0] OP_UNC  = 2'd1;
   localparam logic [1:0] OP_CMP  = 2'd2;

   localparam logic [1:0] KIND_SUBSET  = 2'd0;
   localparam logic [1:0] KIND_SAME    = 2'd1;
   localparam logic [1:0] KIND_MISSING = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   localparam logic [1:0] ERR_NONE         = 2'd0;
   localparam logic [1:0] ERR_MISSING_BASE = 2'd1;
   localparam logic [1:0] ERR_WIDTH        = 2'd2;
   localparam logic [1:0] ERR_OVERFLOW     = 2'd3;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_UNC_VALUE,
      PH_CMP_BASE,
      PH_CMP_DWIDTH,
      PH_CMP_DIFF
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMD,
      ST_BITS
   } seq_state_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  data_byte;
      logic [5:0]  width;
      logic [10:0] subset_count;
      logic        missing_allowed;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [9:0]  subset_index;
      logic [31:0] value;
      logic        is_missing;
      logic [1:0]  error_code;
      logic        last;
   } rsp_type;

   typedef struct packed {
      phase_type           phase;
      logic [BUF_BITS-1:0] bit_buffer;
      logic [HELD_W-1:0]   bits_held;
      logic [5:0]          element_width;
      logic [10:0]         subsets_total;
      logic                exempt_flag;
      logic [31:0]         base_value;
      logic [5:0]          diff_width;
      logic [31:0]         field_accum;
      logic [5:0]          bits_gathered;
      logic [10:0]         subset_counter;
   } elem_type;

   function automatic logic [31:0] ones_of(input logic [5:0] w);
      logic [31:0] mask;
      if (w >= 6'd32) begin
         mask = '1;
      end else begin
         mask = ~(32'hFFFF_FFFF << w);
      end
      return mask;
   endfunction

   function automatic rsp_type error_rsp(input logic [1:0] code, input logic last);
      rsp_type r;
      r.kind         = KIND_ERROR;
      r.subset_index = '0;
      r.value        = '0;
      r.is_missing   = 1'b0;
      r.error_code   = code;
      r.last         = last;
      return r;
   endfunction

endpackage

@@ sv/bnfu_take_bit.sv @@
// Shared one-bit step: takes the next buffered bit and advances the element.
module bnfu_take_bit
   import bnfu_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  elem_type cur,
   output elem_type nxt,
   output logic     emit,
   output rsp_type  rsp
);

   logic              bit_val;
   logic [HELD_W-1:0] held_n;
   logic [31:0]       accum_n;
   logic [5:0]        gathered_n;
   logic [5:0]        dw;
   logic              base_missing;
   logic [31:0]       sum;
   logic              last;

   always_comb begin
      bit_val    = cur.bit_buffer[4'(cur.bits_held - 5'd1)];
      held_n     = cur.bits_held - 5'd1;
      accum_n    = {cur.field_accum[30:0], bit_val};
      gathered_n = cur.bits_gathered + 6'd1;
      dw         = accum_n[5:0];
      base_missing = (cur.base_value == ones_of(cur.element_width));
      sum        = cur.base_value + accum_n;
      last       = ({1'b0, cur.subset_counter} + 12'd1) >= {1'b0, cur.subsets_total};

      nxt = cur;
      nxt.bits_held     = held_n;
      nxt.bit_buffer    = cur.bit_buffer & ~(16'hFFFF << held_n);
      nxt.field_accum   = accum_n;
      nxt.bits_gathered = gathered_n;
      emit = 1'b0;
      rsp  = error_rsp(ERR_NONE, 1'b0);

      case (cur.phase)
         PH_UNC_VALUE: begin
            if (gathered_n >= cur.element_width) begin
               emit = 1'b1;
               rsp.kind       = KIND_SUBSET;
               rsp.value      = accum_n;
               rsp.is_missing = !cur.exempt_flag && (accum_n == ones_of(cur.element_width));
               rsp.last       = 1'b1;
               nxt.phase      = PH_IDLE;
            end
         end
         PH_CMP_BASE: begin
            if (gathered_n >= cur.element_width) begin
               nxt.base_value    = accum_n;
               nxt.field_accum   = '0;
               nxt.bits_gathered = '0;
               nxt.phase         = PH_CMP_DWIDTH;
            end
         end
         PH_CMP_DWIDTH: begin
            if (gathered_n >= 6'(DIFF_WIDTH_BITS)) begin
               nxt.diff_width    = dw;
               nxt.field_accum   = '0;
               nxt.bits_gathered = '0;
               if (base_missing && dw != 6'd0) begin
                  emit = 1'b1;
                  rsp  = error_rsp(ERR_MISSING_BASE, 1'b1);
                  nxt.phase = PH_IDLE;
               end else if (int'(dw) > MAX_WIDTH) begin
                  emit = 1'b1;
                  rsp  = error_rsp(ERR_WIDTH, 1'b1);
                  nxt.phase = PH_IDLE;
               end else if (base_missing) begin
                  emit = 1'b1;
                  rsp.kind       = KIND_MISSING;
                  rsp.value      = cur.base_value;
                  rsp.is_missing = 1'b1;
                  rsp.last       = 1'b1;
                  nxt.phase      = PH_IDLE;
               end else if (dw == 6'd0) begin
                  emit = 1'b1;
                  rsp.kind  = KIND_SAME;
                  rsp.value = cur.base_value;
                  rsp.last  = 1'b1;
                  nxt.phase = PH_IDLE;
               end else begin
                  nxt.subset_counter = '0;
                  nxt.phase          = PH_CMP_DIFF;
               end
            end
         end
         PH_CMP_DIFF: begin
            if (gathered_n >= cur.diff_width) begin
               emit = 1'b1;
               rsp.kind         = KIND_SUBSET;
               rsp.subset_index = cur.subset_counter[9:0];
               rsp.value        = sum;
               rsp.is_missing   = (accum_n == ones_of(cur.diff_width)) ||
                                  (sum == ones_of(cur.element_width));
               rsp.last         = last;
               nxt.subset_counter = cur.subset_counter + 11'd1;
               nxt.field_accum    = '0;
               nxt.bits_gathered  = '0;
               if (last) begin
                  nxt.phase = PH_IDLE;
               end
            end
         end
         default: begin
            nxt.phase = PH_IDLE;
         end
      endcase
   end

endmodule

@@ sv/bufr_numeric_field_unpack.sv @@
// Top level of the BUFR numeric field unpacker.
// Each transaction is either a data byte or the start of a numeric element. The block
// takes one transaction at a time: it accepts it in the idle state, applies the command
// or appends the byte to the 16-bit bit buffer, then lets the shared one-bit step unit
// consume buffered bits one at a time (at most eight per transaction) and returns to idle.
// A dropped byte, a bad element width or an unknown command goes back to idle straight
// from the command state. Each result is held in an output register; while that
// register is full and not taken, the bit loop waits.
module bufr_numeric_field_unpack
   import bnfu_pkg::*;
#(
   parameter int MAX_SUBSETS = DEF_MAX_SUBSETS,
   parameter int MAX_WIDTH   = DEF_MAX_WIDTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   seq_state_type     state_ff, state_in;
   elem_type          elem_ff, elem_in;
   logic [STEP_W-1:0] used_ff, used_in;
   req_type           item_ff, item_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   elem_type          step_nxt;
   logic              step_emit;
   rsp_type           step_rsp;
   logic              slot_free;
   logic              load;
   logic              bad_width;
   logic [10:0]       sc_sat;

   bnfu_take_bit #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_take_bit (
      .cur (elem_ff),
      .nxt (step_nxt),
      .emit(step_emit),
      .rsp (step_rsp)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      bad_width = (item_ff.width == 6'd0) || (int'(item_ff.width) > MAX_WIDTH);
      if (item_ff.subset_count == 11'd0) begin
         sc_sat = 11'd1;
      end else if (int'(item_ff.subset_count) > MAX_SUBSETS) begin
         sc_sat = 11'(MAX_SUBSETS);
      end else begin
         sc_sat = item_ff.subset_count;
      end
   end

   always_comb begin
      state_in    = state_ff;
      elem_in     = elem_ff;
      used_in     = used_ff;
      item_in     = item_ff;
      load        = 1'b0;
      rsp_data_in = step_rsp;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = ST_CMD;
            end
         end
         ST_CMD: begin
            used_in = '0;
            case (item_ff.op)
               OP_DATA: begin
                  if (elem_ff.bits_held > 5'(BUF_BITS - 8)) begin
                     rsp_data_in = error_rsp(ERR_OVERFLOW, 1'b0);
                     if (slot_free) begin
                        load     = 1'b1;
                        state_in = ST_IDLE;
                     end
                  end else begin
                     elem_in.bit_buffer = {elem_ff.bit_buffer[7:0], item_ff.data_byte};
                     elem_in.bits_held  = elem_ff.bits_held + 5'd8;
                     state_in           = ST_BITS;
                  end
               end
               OP_UNC, OP_CMP: begin
                  if (bad_width) begin
                     rsp_data_in = error_rsp(ERR_WIDTH, 1'b1);
                     if (slot_free) begin
                        load                   = 1'b1;
                        elem_in.phase          = PH_IDLE;
                        elem_in.field_accum    = '0;
                        elem_in.bits_gathered  = '0;
                        elem_in.subset_counter = '0;
                        state_in               = ST_IDLE;
                     end
                  end else begin
                     elem_in.field_accum    = '0;
                     elem_in.bits_gathered  = '0;
                     elem_in.subset_counter = '0;
                     elem_in.element_width  = item_ff.width;
                     if (item_ff.op == OP_UNC) begin
                        elem_in.exempt_flag = !item_ff.missing_allowed;
                        elem_in.phase       = PH_UNC_VALUE;
                     end else begin
                        elem_in.subsets_total = sc_sat;
                        elem_in.exempt_flag   = 1'b0;
                        elem_in.phase         = PH_CMP_BASE;
                     end
                     state_in = ST_BITS;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_BITS: begin
            if (elem_ff.phase == PH_IDLE || elem_ff.bits_held == '0 ||
                used_ff == STEP_W'(BITS_PER_STEP)) begin
               state_in = ST_IDLE;
            end else if (!step_emit || slot_free) begin
               elem_in = step_nxt;
               used_in = used_ff + STEP_W'(1);
               load    = step_emit;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         elem_ff      <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         elem_ff      <= elem_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

@@ sv/bnfu_checker.sv @@
// Port-level checker of the numeric field unpacker and its bind.
`include "bufr_numeric_field_unpack_assert.svh"

module bnfu_checker
   import bnfu_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   `BNFU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "Result dropped before it was taken.")
   `BNFU_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_data), "Stalled result changed.")
   `BNFU_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "Ready right after a transaction.")
   `BNFU_ASSERT_IMPLY(a_error_payload, rsp_valid && rsp_data.kind == KIND_ERROR, rsp_data.value == 32'd0 && !rsp_data.is_missing && rsp_data.error_code != ERR_NONE, "Malformed error result.")
   `BNFU_ASSERT_IMPLY(a_error_last, rsp_valid && rsp_data.kind == KIND_ERROR, (rsp_data.error_code == ERR_OVERFLOW) == !rsp_data.last, "Error result has the wrong last flag.")

endmodule

bind bufr_numeric_field_unpack bnfu_checker u_checker (.*);

@@ bench/bufr_numeric_field_unpack_tb.sv @@
// Self-checking testbench for the BUFR numeric field unpacker, with directed and random streams.
module bufr_numeric_field_unpack_tb;
   import bnfu_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS  = 85;
   localparam int BIG_SUBSETS   = 128;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 30;
   localparam int PRINT_LIMIT   = 40;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   bufr_numeric_field_unpack DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   req_type item_q[$];
   req_type deferred_starts[$];
   bit      unsent_bits[$];
   rsp_type field_results_q[$];

   int items_sent   = 0;
   int results_seen = 0;
   int mismatches   = 0;
   int hold_left    = 0;
   bit hold_done    = 1'b0;

   logic [15:0] bitbuf       = '0;
   int          held         = 0;
   phase_type   phase        = PH_IDLE;
   int          elem_width   = 0;
   int          subset_total = 0;
   logic        exempt       = 1'b0;
   logic [31:0] base         = '0;
   int          dwidth       = 0;
   logic [31:0] accum        = '0;
   int          gathered     = 0;
   int          subset_num   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] low_mask(input int w);
      logic [63:0] m;
      m = (64'd1 << w) - 64'd1;
      return m[31:0];
   endfunction

   function automatic rsp_type make_rsp(input logic [1:0] kind, input int index,
                                        input logic [31:0] value, input logic missing,
                                        input logic [1:0] code, input logic fin);
      rsp_type r;
      r.kind         = kind;
      r.subset_index = 10'(index);
      r.value        = value;
      r.is_missing   = missing;
      r.error_code   = code;
      r.last         = fin;
      return r;
   endfunction

   task automatic unpack_transaction(input req_type t);
      int          steps;
      logic        b;
      logic [31:0] v;
      logic        base_miss;
      logic        fin;
      if (t.op == OP_DATA) begin
         if (held + 8 > BUF_BITS) begin
            field_results_q.push_back(make_rsp(KIND_ERROR, 0, '0, 1'b0, ERR_OVERFLOW, 1'b0));
            return;
         end
         bitbuf = {bitbuf[7:0], t.data_byte};
         held   = held + 8;
      end else if (t.op == OP_UNC || t.op == OP_CMP) begin
         accum      = '0;
         gathered   = 0;
         subset_num = 0;
         if (t.width == 0 || t.width > DEF_MAX_WIDTH) begin
            phase = PH_IDLE;
            field_results_q.push_back(make_rsp(KIND_ERROR, 0, '0, 1'b0, ERR_WIDTH, 1'b1));
            return;
         end
         elem_width = t.width;
         if (t.op == OP_UNC) begin
            exempt = !t.missing_allowed;
            phase  = PH_UNC_VALUE;
         end else begin
            subset_total = (t.subset_count == 0) ? 1 :
                           (t.subset_count > DEF_MAX_SUBSETS) ? DEF_MAX_SUBSETS :
                           int'(t.subset_count);
            exempt = 1'b0;
            phase  = PH_CMP_BASE;
         end
      end else begin
         return;
      end
      steps = 0;
      while (phase != PH_IDLE && held > 0 && steps < BITS_PER_STEP) begin
         b        = bitbuf[held-1];
         held     = held - 1;
         bitbuf   = bitbuf & 16'(low_mask(held));
         accum    = {accum[30:0], b};
         gathered = gathered + 1;
         steps    = steps + 1;
         case (phase)
            PH_UNC_VALUE: begin
               if (gathered >= elem_width) begin
                  field_results_q.push_back(make_rsp(KIND_SUBSET, 0, accum,
                     !exempt && accum == low_mask(elem_width), ERR_NONE, 1'b1));
                  phase = PH_IDLE;
               end
            end
            PH_CMP_BASE: begin
               if (gathered >= elem_width) begin
                  base     = accum;
                  accum    = '0;
                  gathered = 0;
                  phase    = PH_CMP_DWIDTH;
               end
            end
            PH_CMP_DWIDTH: begin
               if (gathered >= DIFF_WIDTH_BITS) begin
                  dwidth    = int'(accum[5:0]);
                  base_miss = (base == low_mask(elem_width));
                  accum     = '0;
                  gathered  = 0;
                  phase     = PH_IDLE;
                  if (base_miss && dwidth != 0) begin
                     field_results_q.push_back(make_rsp(KIND_ERROR, 0, '0, 1'b0,
                                                        ERR_MISSING_BASE, 1'b1));
                  end else if (dwidth > DEF_MAX_WIDTH) begin
                     field_results_q.push_back(make_rsp(KIND_ERROR, 0, '0, 1'b0,
                                                        ERR_WIDTH, 1'b1));
                  end else if (base_miss) begin
                     field_results_q.push_back(make_rsp(KIND_MISSING, 0, base, 1'b1,
                                                        ERR_NONE, 1'b1));
                  end else if (dwidth == 0) begin
                     field_results_q.push_back(make_rsp(KIND_SAME, 0, base, 1'b0,
                                                        ERR_NONE, 1'b1));
                  end else begin
                     subset_num = 0;
                     phase      = PH_CMP_DIFF;
                  end
               end
            end
            PH_CMP_DIFF: begin
               if (gathered >= dwidth) begin
                  v   = base + accum;
                  fin = (subset_num + 1 >= subset_total);
                  field_results_q.push_back(make_rsp(KIND_SUBSET, subset_num, v,
                     accum == low_mask(dwidth) || v == low_mask(elem_width), ERR_NONE, fin));
                  subset_num = subset_num + 1;
                  accum      = '0;
                  gathered   = 0;
                  if (fin) begin
                     phase = PH_IDLE;
                  end
               end
            end
            default: begin
               phase = PH_IDLE;
            end
         endcase
      end
   endtask

   function automatic req_type data_item(input logic [7:0] value);
      req_type t;
      t.op              = OP_DATA;
      t.data_byte       = value;
      t.width           = 6'($urandom);
      t.subset_count    = 11'($urandom);
      t.missing_allowed = 1'($urandom);
      return t;
   endfunction

   // An element may only start once every bit of the previous element has been sent, so
   // a start is held back until the byte that carries the previous element's tail goes out.
   task automatic start_element(input logic [1:0] op, input int w, input int sc,
                                input logic allow);
      req_type t;
      t.op              = op;
      t.data_byte       = 8'($urandom);
      t.width           = 6'(w);
      t.subset_count    = 11'(sc);
      t.missing_allowed = allow;
      if (unsent_bits.size() == 0) begin
         item_q.push_back(t);
      end else begin
         deferred_starts.push_back(t);
      end
   endtask

   task automatic push_bits(input logic [31:0] value, input int n);
      logic [7:0] byte_v;
      for (int i = n - 1; i >= 0; i--) begin
         unsent_bits.push_back(value[i]);
      end
      while (unsent_bits.size() >= 8) begin
         for (int i = 0; i < 8; i++) begin
            byte_v = {byte_v[6:0], unsent_bits.pop_front()};
         end
         item_q.push_back(data_item(byte_v));
         while (deferred_starts.size() > 0) begin
            item_q.push_back(deferred_starts.pop_front());
         end
      end
   endtask

   task automatic pad_out();
      if (unsent_bits.size() > 0) begin
         push_bits($urandom, 8 - unsent_bits.size());
      end
   endtask

   // Two wide uncompressed starts swallow whatever the bit buffer still holds.
   task automatic resync();
      pad_out();
      repeat (2) start_element(OP_UNC, DEF_MAX_WIDTH, $urandom_range(2047), 1'($urandom));
   endtask

   task automatic gen_unc(input int w, input logic allow, input logic [31:0] value);
      start_element(OP_UNC, w, $urandom_range(2047), allow);
      if (w >= 1 && w <= DEF_MAX_WIDTH) begin
         push_bits(value, w);
      end
   endtask

   task automatic gen_cmp(input int w, input int sc, input logic [31:0] base_v, input int dw);
      int          n;
      logic [31:0] d;
      start_element(OP_CMP, w, sc, 1'($urandom));
      if (w < 1 || w > DEF_MAX_WIDTH) begin
         return;
      end
      base_v = base_v & low_mask(w);
      push_bits(base_v, w);
      push_bits(32'(dw), DIFF_WIDTH_BITS);
      if (dw == 0 || dw > DEF_MAX_WIDTH || base_v == low_mask(w)) begin
         return;
      end
      n = (sc < 1) ? 1 : (sc > DEF_MAX_SUBSETS) ? DEF_MAX_SUBSETS : sc;
      repeat (n) begin
         case ($urandom_range(7))
            0: d = low_mask(dw);
            1: d = (low_mask(w) - base_v) & low_mask(dw);
            default: d = $urandom & low_mask(dw);
         endcase
         push_bits(d, dw);
      end
   endtask

   task automatic gen_element();
      int          w;
      int          sc;
      int          dw;
      logic [31:0] v;
      w = ($urandom_range(7) == 0) ? DEF_MAX_WIDTH : $urandom_range(1, 20);
      v = $urandom & low_mask(w);
      if ($urandom_range(4) == 0) begin
         v = low_mask(w);
      end
      if ($urandom_range(2) == 0) begin
         gen_unc(w, 1'($urandom), v);
      end else begin
         case ($urandom_range(15))
            0, 1: dw = 0;
            2: dw = $urandom_range(DEF_MAX_WIDTH + 1, 63);
            3: dw = $urandom_range(13, DEF_MAX_WIDTH);
            default: dw = $urandom_range(1, 12);
         endcase
         sc = $urandom_range(1, 6);
         if (dw == 0 || dw > DEF_MAX_WIDTH || v == low_mask(w)) begin
            sc = $urandom_range(2047);
         end
         gen_cmp(w, sc, v, dw);
      end
   endtask

   task automatic gen_noise();
      req_type t;
      if ($urandom_range(1) == 0) begin
         start_element(2'($urandom_range(OP_UNC, OP_CMP)), $urandom_range(1, DEF_MAX_WIDTH),
                       $urandom_range(2047), 1'($urandom));
         push_bits($urandom, $urandom_range(1, 20));
      end
      pad_out();
      repeat ($urandom_range(1, 5)) begin
         t    = data_item(8'($urandom));
         t.op = 2'($urandom_range(3));
         item_q.push_back(t);
      end
      resync();
   endtask

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_LIMIT) begin
         $display("MISMATCH at %0t: %s", $time, msg);
      end
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            unpack_transaction(req_data);
            items_sent <= items_sent + 1;
         end
         if (!req_valid || req_ready) begin
            if (item_q.size() > 0 &&
                ((items_sent >= 40 && items_sent < 100) || $urandom_range(99) >= 20)) begin
               req_data  <= item_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && !hold_done && results_seen >= 30) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin : result_check
      rsp_type want;
      string   diffs;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            if (field_results_q.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing expected",
                                         results_seen));
            end else begin
               want  = field_results_q.pop_front();
               diffs = "";
               if (rsp_data.kind != want.kind) begin
                  diffs = {diffs, $sformatf(" kind %0d/%0d", rsp_data.kind, want.kind)};
               end
               if (rsp_data.subset_index != want.subset_index) begin
                  diffs = {diffs, $sformatf(" subset_index %0d/%0d",
                                            rsp_data.subset_index, want.subset_index)};
               end
               if (rsp_data.value != want.value) begin
                  diffs = {diffs, $sformatf(" value %h/%h", rsp_data.value, want.value)};
               end
               if (rsp_data.is_missing != want.is_missing) begin
                  diffs = {diffs, $sformatf(" is_missing %0d/%0d",
                                            rsp_data.is_missing, want.is_missing)};
               end
               if (rsp_data.error_code != want.error_code) begin
                  diffs = {diffs, $sformatf(" error_code %0d/%0d",
                                            rsp_data.error_code, want.error_code)};
               end
               if (rsp_data.last != want.last) begin
                  diffs = {diffs, $sformatf(" last %0d/%0d", rsp_data.last, want.last)};
               end
               if (diffs != "") begin
                  report_mismatch($sformatf("result %0d (got/expected):%s",
                                            results_seen, diffs));
               end
            end
         end
         rsp_ready <= (hold_left == 0) &&
                      ((results_seen >= 60 && results_seen < 160) || $urandom_range(99) >= 20);
      end
   end

   initial begin
      int first_random;
      bit big_done;
      big_done = 1'b0;

      item_q.push_back(data_item(8'hA5));
      start_element(OP_UNC, 8, 0, 1'b1);
      gen_unc(4, 1'b1, 32'hF);
      gen_unc(4, 1'b0, 32'hF);
      gen_cmp(8, 0, 32'h10, 3);
      gen_cmp(4, 5, 32'hF, 5);
      gen_cmp(5, 1, 32'h3, 40);
      gen_cmp(DEF_MAX_WIDTH, 2047, 32'hFFFF_FFFF, 0);
      gen_cmp(7, 4, 32'h5, 0);
      start_element(OP_CMP, 8, 3, 1'b1);
      push_bits(32'hFE, 8);
      push_bits(32'd2, DIFF_WIDTH_BITS);
      push_bits(32'd3, 2);
      push_bits(32'd1, 2);
      push_bits(32'd0, 2);
      pad_out();
      start_element(OP_UNC, 0, 2047, 1'b1);
      start_element(OP_CMP, 63, 1024, 1'b0);
      begin
         req_type t;
         t    = data_item(8'h00);
         t.op = OP_UNUSED;
         item_q.push_back(t);
      end
      repeat (3) item_q.push_back(data_item(8'($urandom)));
      resync();

      first_random = item_q.size();
      while (item_q.size() < first_random + RANDOM_ITEMS) begin
         if (!big_done && item_q.size() >= first_random + RANDOM_ITEMS / 2) begin
            gen_cmp($urandom_range(2, DEF_MAX_WIDTH), BIG_SUBSETS, $urandom & ~32'd1, 1);
            big_done = 1'b1;
         end else if ($urandom_range(11) == 0) begin
            gen_noise();
         end else begin
            gen_element();
         end
      end
      pad_out();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (item_q.size() > 0 || req_valid) @(posedge clock);
      while (field_results_q.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

@@ bufr_numeric_field_unpack.f @@
+incdir+sv
sv/bnfu_pkg.sv
sv/bnfu_take_bit.sv
sv/bufr_numeric_field_unpack.sv
sv/bnfu_checker.sv
bench/bufr_numeric_field_unpack_tb.sv
